// ----- hdl/tlbpt_pkg.sv -----
// Shared types and constants for the TLB page table translator.
// No dependencies.
package tlbpt_pkg;

    localparam int ADDR_W        = 64;
    localparam int TLB_SIZE_W    = 5;
    localparam int FRAME_COUNT_W = 11;
    localparam int PFN_WIDTH_W   = 5;
    localparam int VPN_WIDTH_W   = 4;
    localparam int COUNT_OUT_W   = 11;
    localparam int ENTRY_OUT_W   = 5;
    localparam int PFN_MAX       = 16;

    localparam int DEF_TLB_DEPTH     = 16;
    localparam int DEF_MAX_FRAMES    = 1024;
    localparam int DEF_MAX_PAGE_BITS = 10;

    localparam logic [TLB_SIZE_W-1:0]    RST_TLB_SIZE    = 5'd16;
    localparam logic [FRAME_COUNT_W-1:0] RST_FRAME_COUNT = 11'd1024;
    localparam logic [PFN_WIDTH_W-1:0]   RST_PFN_WIDTH   = 5'd10;
    localparam logic [VPN_WIDTH_W-1:0]   RST_VPN_WIDTH   = 4'd10;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_TLB_SIZE    = 2'd0,
        REG_FRAME_COUNT = 2'd1,
        REG_PFN_WIDTH   = 2'd2,
        REG_VPN_WIDTH   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TLB,
        ST_PT,
        ST_RES,
        ST_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic pt_read;
        logic resolve;
    } cmd_t;

    typedef struct packed {
        logic [TLB_SIZE_W-1:0]    tlb_size;
        logic [FRAME_COUNT_W-1:0] frame_count;
        logic [PFN_WIDTH_W-1:0]   pfn_width;
        logic [VPN_WIDTH_W-1:0]   vpn_width;
    } cfg_t;

endpackage

// ----- hdl/tlb_page_table_translator.sv -----
// Top level: APB configuration registers, sequencer and datapath.
// Depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_datapath.
//
// Usage: raise start with vaddr while busy is low; the transfer is
// taken at that edge and busy rises. After the resolve step, done is high
// for one cycle with phys_address, tlb_hit, fresh_frame, out_of_frames and
// the status counters; that cycle is the result transfer and cannot be held
// off. busy falls after the done cycle, and no new item is taken before the
// last one is through. The steps are TLB compare with page table read,
// frame check read, resolve, report, with the two page table memories read
// in separate steps.
// Configuration goes through the APB port (registers at 0x0, 0x4, 0x8, 0xC);
// any write clears the TLB, page table and counters. Write only while idle.
// Reset restores register defaults and empties all tables at once; no
// clearing pass is needed because page table entries are checked against
// the allocation count.
module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_DEPTH     = DEF_TLB_DEPTH,
    parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
    parameter int MAX_PAGE_BITS = DEF_MAX_PAGE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   start,
    output logic                   busy,
    input  logic [ADDR_W-1:0]      vaddr,
    output logic                   done,
    output logic [ADDR_W-1:0]      phys_address,
    output logic                   tlb_hit,
    output logic                   fresh_frame,
    output logic                   out_of_frames,
    output logic [COUNT_OUT_W-1:0] free_frames,
    output logic [COUNT_OUT_W-1:0] allocated_pages,
    output logic [ENTRY_OUT_W-1:0] tlb_entries
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t wr_idx;
    cmd_t     cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[3:2]);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tlb_size    <= RST_TLB_SIZE;
            cfg_reg.frame_count <= RST_FRAME_COUNT;
            cfg_reg.pfn_width   <= RST_PFN_WIDTH;
            cfg_reg.vpn_width   <= RST_VPN_WIDTH;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_TLB_SIZE:    cfg_reg.tlb_size    <= pwdata[TLB_SIZE_W-1:0];
                REG_FRAME_COUNT: cfg_reg.frame_count <= pwdata[FRAME_COUNT_W-1:0];
                REG_PFN_WIDTH:   cfg_reg.pfn_width   <= pwdata[PFN_WIDTH_W-1:0];
                REG_VPN_WIDTH:   cfg_reg.vpn_width   <= pwdata[VPN_WIDTH_W-1:0];
                default:         cfg_reg.tlb_size    <= cfg_reg.tlb_size;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (wr_idx)
            REG_TLB_SIZE:    prdata = 32'(cfg_reg.tlb_size);
            REG_FRAME_COUNT: prdata = 32'(cfg_reg.frame_count);
            REG_PFN_WIDTH:   prdata = 32'(cfg_reg.pfn_width);
            REG_VPN_WIDTH:   prdata = 32'(cfg_reg.vpn_width);
            default:         prdata = '0;
        endcase
    end

    tlbpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    tlbpt_datapath #(
        .TLB_DEPTH     (TLB_DEPTH),
        .MAX_FRAMES    (MAX_FRAMES),
        .MAX_PAGE_BITS (MAX_PAGE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .clear           (wr_en),
        .cfg             (cfg_reg),
        .vaddr           (vaddr),
        .phys_address    (phys_address),
        .tlb_hit         (tlb_hit),
        .fresh_frame     (fresh_frame),
        .out_of_frames   (out_of_frames),
        .free_frames     (free_frames),
        .allocated_pages (allocated_pages),
        .tlb_entries     (tlb_entries)
    );

endmodule

// ----- hdl/tlbpt_ctrl.sv -----
// Sequencer for one translation: capture, TLB lookup, page table read, resolve, report.
// Depends on tlbpt_pkg.
module tlbpt_ctrl
    import tlbpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_TLB;
            ST_TLB:  state_next = ST_PT;
            ST_PT:   state_next = ST_RES;
            ST_RES:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        cmd.capture = (state_reg == ST_IDLE) && start;
        cmd.lookup  = (state_reg == ST_TLB);
        cmd.pt_read = (state_reg == ST_PT);
        cmd.resolve = (state_reg == ST_RES);
        busy        = (state_reg != ST_IDLE);
        done        = (state_reg == ST_OUT);
    end

endmodule

// ----- hdl/tlbpt_datapath.sv -----
// TLB, page table memories, frame allocator and result registers.
// Depends on tlbpt_pkg; driven by tlbpt_ctrl commands.
module tlbpt_datapath
    import tlbpt_pkg::*;
#(
    parameter int TLB_DEPTH     = DEF_TLB_DEPTH,
    parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
    parameter int MAX_PAGE_BITS = DEF_MAX_PAGE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic                   clear,
    input  cfg_t                   cfg,
    input  logic [ADDR_W-1:0]      vaddr,
    output logic [ADDR_W-1:0]      phys_address,
    output logic                   tlb_hit,
    output logic                   fresh_frame,
    output logic                   out_of_frames,
    output logic [COUNT_OUT_W-1:0] free_frames,
    output logic [COUNT_OUT_W-1:0] allocated_pages,
    output logic [ENTRY_OUT_W-1:0] tlb_entries
);

    localparam int TW   = $clog2(TLB_DEPTH + 1);
    localparam int PW   = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int FW   = $clog2(MAX_FRAMES);
    localparam int CW   = $clog2(MAX_FRAMES + 1);
    localparam int PGW  = MAX_PAGE_BITS;
    localparam int PAGES = 1 << PGW;
    localparam int SHW  = 7;
    localparam int XW   = (CW > FRAME_COUNT_W) ? CW : FRAME_COUNT_W;

    // Effective configuration
    logic [TW-1:0] eff_tlb;
    logic [CW-1:0] eff_frames;
    logic [PFN_WIDTH_W-1:0] eff_pfn;
    logic [VPN_WIDTH_W-1:0] eff_vpn;

    always_comb
    begin
        if (cfg.tlb_size == '0)
            eff_tlb = TW'(1);
        else if (7'(cfg.tlb_size) > 7'(TLB_DEPTH))
            eff_tlb = TW'(TLB_DEPTH);
        else
            eff_tlb = TW'(cfg.tlb_size);
        if (XW'(cfg.frame_count) > XW'(MAX_FRAMES))
            eff_frames = CW'(MAX_FRAMES);
        else
            eff_frames = CW'(cfg.frame_count);
        if (cfg.pfn_width == '0)
            eff_pfn = PFN_WIDTH_W'(1);
        else if (cfg.pfn_width > PFN_WIDTH_W'(PFN_MAX))
            eff_pfn = PFN_WIDTH_W'(PFN_MAX);
        else
            eff_pfn = cfg.pfn_width;
        if (cfg.vpn_width == '0)
            eff_vpn = VPN_WIDTH_W'(1);
        else if (5'(cfg.vpn_width) > 5'(MAX_PAGE_BITS))
            eff_vpn = VPN_WIDTH_W'(MAX_PAGE_BITS);
        else
            eff_vpn = cfg.vpn_width;
    end

    // Captured request
    logic [ADDR_W-1:0] va_reg;
    logic [PGW-1:0]    page_reg;
    logic [ADDR_W-1:0] page_shift;

    assign page_shift = vaddr >> (SHW'(ADDR_W) - SHW'(eff_vpn));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            va_reg   <= vaddr;
            page_reg <= page_shift[PGW-1:0];
        end
    end

    // TLB storage and control counters
    logic [PGW-1:0] tlb_page_reg  [TLB_DEPTH];
    logic [FW-1:0]  tlb_frame_reg [TLB_DEPTH];
    logic [TLB_DEPTH-1:0] tlb_valid_reg;
    logic [PW-1:0]  fifo_ptr_reg;
    logic [TW-1:0]  vcount_reg;
    logic [CW-1:0]  alloc_reg;

    // Parallel TLB compare, lowest match wins
    logic          match;
    logic [FW-1:0] match_frame;

    always_comb
    begin
        match       = 1'b0;
        match_frame = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && tlb_page_reg[i] == page_reg)
            begin
                match       = 1'b1;
                match_frame = tlb_frame_reg[i];
            end
        end
    end

    logic          hit_q;
    logic [FW-1:0] hit_frame_q;

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_q       <= match;
            hit_frame_q <= match_frame;
        end
    end

    // Page table: page to frame, and frame to page as a membership check
    logic [FW-1:0]  page_frame_mem [PAGES];
    logic [PGW-1:0] frame_page_mem [MAX_FRAMES];
    logic [FW-1:0]  pf_q;
    logic [PGW-1:0] fp_q;

    logic          mapped;
    logic          can_alloc;
    logic [FW-1:0] alloc_frame;

    // Resolve decision
    logic          fill;
    logic          fresh;
    logic          fault;
    logic [FW-1:0] res_frame;

    assign mapped      = (CW'(pf_q) < alloc_reg) && (fp_q == page_reg);
    assign can_alloc   = alloc_reg < eff_frames;
    assign alloc_frame = alloc_reg[FW-1:0];

    // Page table reads, and mapping of the page on a fresh allocation
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
            pf_q <= page_frame_mem[page_reg];
        if (cmd.pt_read)
            fp_q <= frame_page_mem[pf_q];
        if (cmd.resolve && fresh)
        begin
            page_frame_mem[page_reg]    <= alloc_frame;
            frame_page_mem[alloc_frame] <= page_reg;
        end
    end

    always_comb
    begin
        fill      = 1'b0;
        fresh     = 1'b0;
        fault     = 1'b0;
        res_frame = hit_frame_q;
        priority if (hit_q)
        begin
            res_frame = hit_frame_q;
        end
        else if (mapped)
        begin
            res_frame = pf_q;
            fill      = 1'b1;
        end
        else if (can_alloc)
        begin
            res_frame = alloc_frame;
            fill      = 1'b1;
            fresh     = 1'b1;
        end
        else
        begin
            fault = 1'b1;
        end
    end

    // Physical address assembly in 64 bits
    logic [ADDR_W-1:0] frame_part;
    logic [ADDR_W-1:0] off_mask;
    logic [ADDR_W-1:0] phys_calc;

    assign frame_part = ADDR_W'(res_frame) << (SHW'(ADDR_W) - SHW'(eff_pfn));
    assign off_mask   = {ADDR_W{1'b1}} >> eff_pfn;
    assign phys_calc  = fault ? '0 : (frame_part | (va_reg & off_mask));

    // TLB fill and counters
    logic [PW-1:0] ptr_inc;
    assign ptr_inc = fifo_ptr_reg + PW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.resolve && fill)
        begin
            tlb_page_reg[fifo_ptr_reg]  <= page_reg;
            tlb_frame_reg[fifo_ptr_reg] <= res_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg <= '0;
            fifo_ptr_reg  <= '0;
            vcount_reg    <= '0;
            alloc_reg     <= '0;
        end
        else if (clear)
        begin
            tlb_valid_reg <= '0;
            fifo_ptr_reg  <= '0;
            vcount_reg    <= '0;
            alloc_reg     <= '0;
        end
        else if (cmd.resolve)
        begin
            if (fill)
            begin
                tlb_valid_reg[fifo_ptr_reg] <= 1'b1;
                if (TW'(ptr_inc) >= eff_tlb || ptr_inc == '0)
                    fifo_ptr_reg <= '0;
                else
                    fifo_ptr_reg <= ptr_inc;
                if (vcount_reg < eff_tlb)
                    vcount_reg <= vcount_reg + TW'(1);
            end
            if (fresh)
                alloc_reg <= alloc_reg + CW'(1);
        end
    end

    // Result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phys_address  <= '0;
            tlb_hit       <= 1'b0;
            fresh_frame   <= 1'b0;
            out_of_frames <= 1'b0;
        end
        else if (cmd.resolve)
        begin
            phys_address  <= phys_calc;
            tlb_hit       <= hit_q;
            fresh_frame   <= fresh;
            out_of_frames <= fault;
        end
    end

    // Frames are handed out in order, so the free count follows the allocation count
    logic [CW-1:0] free_calc;
    assign free_calc       = eff_frames - alloc_reg;
    assign free_frames     = COUNT_OUT_W'(free_calc);
    assign allocated_pages = COUNT_OUT_W'(alloc_reg);
    assign tlb_entries     = ENTRY_OUT_W'(vcount_reg);

    a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= eff_tlb)
        else $error("valid entry count exceeds TLB size");
    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg <= eff_frames)
        else $error("allocation count exceeds frame count");
    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(tlb_hit && (fresh_frame || out_of_frames)))
        else $error("hit reported together with allocation or fault");
    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resolve && !clear |=> (alloc_reg == $past(alloc_reg) + CW'(fresh_frame)))
        else $error("allocation count out of step with fresh frame flag");

endmodule

// ----- bench/tb_tlb_page_table_translator.sv -----
// Self-checking testbench for tlb_page_table_translator: an in-bench TLB and
// page table predictor checks every result strobe against queued expectations.
// Depends on tlbpt_pkg and the RTL of tlb_page_table_translator.
module tb_tlb_page_table_translator;
    import tlbpt_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]      pa;
        logic                   hit;
        logic                   fresh;
        logic                   oof;
        logic [COUNT_OUT_W-1:0] nfree;
        logic [COUNT_OUT_W-1:0] nalloc;
        logic [ENTRY_OUT_W-1:0] nvalid;
    } xlat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start = 1'b0;
    logic              busy;
    logic [ADDR_W-1:0] vaddr = '0;
    logic              done;
    logic [ADDR_W-1:0] phys_address;
    logic              tlb_hit;
    logic              fresh_frame;
    logic              out_of_frames;
    logic [COUNT_OUT_W-1:0] free_frames;
    logic [COUNT_OUT_W-1:0] allocated_pages;
    logic [ENTRY_OUT_W-1:0] tlb_entries;

    // Predictor configuration and state
    logic [TLB_SIZE_W-1:0]    cfg_tlb_size;
    logic [FRAME_COUNT_W-1:0] cfg_frames;
    logic [PFN_WIDTH_W-1:0]   cfg_pfn;
    logic [VPN_WIDTH_W-1:0]   cfg_vpn;
    logic [9:0] tlb_vpn [16];
    logic [9:0] tlb_pfn [16];
    logic       tlb_vld [16];
    logic [9:0] pt_frame [1024];
    logic       pt_mapped [1024];
    logic       frame_busy [1024];
    int         fifo_ptr;
    int         valid_cnt;
    int         free_cnt;
    int         alloc_cnt;

    logic [ADDR_W-1:0] va_pending[$];
    xlat_t             xlat_expected[$];
    int                idle_pct = 0;
    int                mismatches = 0;

    tlb_page_table_translator u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .vaddr(vaddr),
        .done(done), .phys_address(phys_address), .tlb_hit(tlb_hit),
        .fresh_frame(fresh_frame), .out_of_frames(out_of_frames),
        .free_frames(free_frames), .allocated_pages(allocated_pages),
        .tlb_entries(tlb_entries)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int eff_tlb();
        return (cfg_tlb_size == 0) ? 1 : (cfg_tlb_size > 16) ? 16 : int'(cfg_tlb_size);
    endfunction

    function automatic int eff_frames();
        return (cfg_frames > 1024) ? 1024 : int'(cfg_frames);
    endfunction

    function automatic int eff_pfn();
        return (cfg_pfn == 0) ? 1 : (cfg_pfn > 16) ? 16 : int'(cfg_pfn);
    endfunction

    function automatic int eff_vpn();
        return (cfg_vpn == 0) ? 1 : (cfg_vpn > 10) ? 10 : int'(cfg_vpn);
    endfunction

    // Any register write empties the TLB and page table
    function automatic void clear_tables();
        for (int i = 0; i < 16; i++)
            tlb_vld[i] = 1'b0;
        for (int i = 0; i < 1024; i++)
        begin
            pt_mapped[i] = 1'b0;
            frame_busy[i] = 1'b0;
        end
        fifo_ptr = 0;
        valid_cnt = 0;
        free_cnt = eff_frames();
        alloc_cnt = 0;
    endfunction

    function automatic void tlb_refill(int vpn, int pfn);
        int sz;
        int slot;
        sz = eff_tlb();
        slot = fifo_ptr % sz;
        tlb_vpn[slot] = vpn[9:0];
        tlb_pfn[slot] = pfn[9:0];
        tlb_vld[slot] = 1'b1;
        fifo_ptr = (slot + 1) % sz;
        if (valid_cnt < sz)
            valid_cnt++;
    endfunction

    // Translate one address and queue the expected result
    function automatic void translate(logic [ADDR_W-1:0] va);
        int vb;
        int pb;
        int vpn;
        int pfn;
        logic [ADDR_W-1:0] offs;
        bit hit;
        bit fresh;
        bit found;
        xlat_t r;
        vb = eff_vpn();
        pb = eff_pfn();
        vpn = int'(va >> (64 - vb));
        offs = va & ((64'd1 << (64 - pb)) - 64'd1);
        pfn = 0;
        hit = 0;
        fresh = 0;
        found = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (!hit && tlb_vld[i] && tlb_vpn[i] == vpn[9:0])
            begin
                pfn = tlb_pfn[i];
                hit = 1;
            end
        end
        if (!hit)
        begin
            if (pt_mapped[vpn])
            begin
                pfn = pt_frame[vpn];
                tlb_refill(vpn, pfn);
                found = 1;
            end
            else
            begin
                for (int i = 0; i < eff_frames(); i++)
                begin
                    if (!found && !frame_busy[i])
                    begin
                        pfn = i;
                        found = 1;
                    end
                end
                if (found)
                begin
                    frame_busy[pfn] = 1'b1;
                    if (free_cnt > 0)
                        free_cnt--;
                    pt_frame[vpn] = pfn[9:0];
                    pt_mapped[vpn] = 1'b1;
                    tlb_refill(vpn, pfn);
                    alloc_cnt++;
                    fresh = 1;
                end
            end
        end
        r.oof = !hit && !found;
        r.pa = r.oof ? '0 : ((64'(pfn) << (64 - pb)) | offs);
        r.hit = hit;
        r.fresh = fresh;
        r.nfree = free_cnt[COUNT_OUT_W-1:0];
        r.nalloc = alloc_cnt[COUNT_OUT_W-1:0];
        r.nvalid = valid_cnt[ENTRY_OUT_W-1:0];
        xlat_expected.push_back(r);
    endfunction

    // Request driver: predicts on each accepted transfer, then offers the next one
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            translate(vaddr);
        if (!start || !busy)
        begin
            if (rst_n && va_pending.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                vaddr <= va_pending.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        xlat_t got;
        xlat_t want;
        if (rst_n && done)
        begin
            got = '{phys_address, tlb_hit, fresh_frame, out_of_frames,
                    free_frames, allocated_pages, tlb_entries};
            if (xlat_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected: %p", got);
            end
            else
            begin
                want = xlat_expected.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Wait until every transfer has been accepted and answered
    task automatic wait_idle();
        do
            @(posedge clk);
        while (va_pending.size() != 0 || start || busy || xlat_expected.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TLB_SIZE:    cfg_tlb_size = val[TLB_SIZE_W-1:0];
            REG_FRAME_COUNT: cfg_frames = val[FRAME_COUNT_W-1:0];
            REG_PFN_WIDTH:   cfg_pfn = val[PFN_WIDTH_W-1:0];
            default:         cfg_vpn = val[VPN_WIDTH_W-1:0];
        endcase
        clear_tables();
    endtask

    // Address whose page mostly comes from a small pool, so hits and refills recur
    function automatic logic [ADDR_W-1:0] pool_va(int pool);
        logic [ADDR_W-1:0] va;
        int vb;
        int pg;
        va = {$urandom, $urandom};
        if ($urandom_range(99) < 15)
            return va;
        vb = eff_vpn();
        pg = $urandom_range(pool - 1) & ((1 << vb) - 1);
        va = (va & ~({64{1'b1}} << (64 - vb))) | (64'(pg) << (64 - vb));
        return va;
    endfunction

    initial
    begin
        int n;
        int pool;
        cfg_tlb_size = RST_TLB_SIZE;
        cfg_frames = RST_FRAME_COUNT;
        cfg_pfn = RST_PFN_WIDTH;
        cfg_vpn = RST_VPN_WIDTH;
        clear_tables();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, field extremes, repeat hit
        va_pending.push_back('0);
        va_pending.push_back({64{1'b1}});
        va_pending.push_back(64'h0000_0000_0000_1234);
        va_pending.push_back(64'h8000_0000_0000_0000);
        va_pending.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        wait_idle();
        // No frames: every unmapped page faults
        write_reg(REG_FRAME_COUNT, 32'd0);
        va_pending.push_back(64'h1);
        va_pending.push_back({64{1'b1}});
        wait_idle();
        // One frame, one-entry TLB: fault after first allocation, replacement
        write_reg(REG_FRAME_COUNT, 32'd1);
        write_reg(REG_TLB_SIZE, 32'd1);
        va_pending.push_back(64'h0000_0000_0000_0042);
        va_pending.push_back(64'hFFC0_0000_0000_0000);
        va_pending.push_back(64'h0000_0000_0000_0099);
        wait_idle();
        write_reg(REG_FRAME_COUNT, 32'd2);
        va_pending.push_back(64'h0000_0000_0000_0001);
        va_pending.push_back(64'h0040_0000_0000_0002);
        va_pending.push_back(64'h0000_0000_0000_0003);
        va_pending.push_back(64'h0040_0000_0000_0004);
        wait_idle();
        // Width registers at zero, then all registers above their ranges
        write_reg(REG_PFN_WIDTH, 32'd0);
        write_reg(REG_VPN_WIDTH, 32'd0);
        va_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        va_pending.push_back(64'h0123_4567_89AB_CDEF);
        wait_idle();
        write_reg(REG_PFN_WIDTH, 32'd31);
        write_reg(REG_VPN_WIDTH, 32'd15);
        write_reg(REG_TLB_SIZE, 32'd31);
        write_reg(REG_FRAME_COUNT, 32'd2047);
        va_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        va_pending.push_back(64'h5555_5555_5555_5555);
        va_pending.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        wait_idle();

        // Random phases with a fresh configuration each
        for (int ph = 0; ph < 15; ph++)
        begin
            idle_pct = (ph < 5) ? 20 : (ph < 10) ? 58 : 0;
            case ($urandom_range(4))
                0: write_reg(REG_TLB_SIZE, 32'd0);
                1: write_reg(REG_TLB_SIZE, 32'd1);
                2: write_reg(REG_TLB_SIZE, 32'd16);
                3: write_reg(REG_TLB_SIZE, 32'd31);
                default: write_reg(REG_TLB_SIZE, $urandom_range(31));
            endcase
            case ($urandom_range(5))
                0: write_reg(REG_FRAME_COUNT, 32'd0);
                1: write_reg(REG_FRAME_COUNT, 32'd1);
                2: write_reg(REG_FRAME_COUNT, 32'd1024);
                3: write_reg(REG_FRAME_COUNT, 32'd2047);
                default: write_reg(REG_FRAME_COUNT, $urandom_range(40, 1));
            endcase
            case ($urandom_range(4))
                0: write_reg(REG_PFN_WIDTH, 32'd0);
                1: write_reg(REG_PFN_WIDTH, 32'd1);
                2: write_reg(REG_PFN_WIDTH, 32'd16);
                3: write_reg(REG_PFN_WIDTH, 32'd31);
                default: write_reg(REG_PFN_WIDTH, $urandom_range(31));
            endcase
            case ($urandom_range(4))
                0: write_reg(REG_VPN_WIDTH, 32'd0);
                1: write_reg(REG_VPN_WIDTH, 32'd1);
                2: write_reg(REG_VPN_WIDTH, 32'd10);
                3: write_reg(REG_VPN_WIDTH, 32'd15);
                default: write_reg(REG_VPN_WIDTH, $urandom_range(15));
            endcase
            n = $urandom_range(130, 95);
            pool = $urandom_range(48, 4);
            for (int i = 0; i < n; i++)
                va_pending.push_back(pool_va(pool));
            wait_idle();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tlbpt_pkg.sv
hdl/tlbpt_ctrl.sv
hdl/tlbpt_datapath.sv
hdl/tlb_page_table_translator.sv
bench/tb_tlb_page_table_translator.sv
